// File: hdl/gh_pkg.sv
// shared constants, types and the base32 character table of the geohash encoder
`default_nettype none
package gh_pkg;

    localparam int COORD_W         = 34;
    localparam int AXIS_W          = 32;
    localparam int BITS_PER_SYMBOL = 5;
    localparam int SYMBOL_W        = 7;
    localparam int CFG_W           = 4;
    localparam int MAX_SYMBOLS_DEF = 12;
    localparam logic [CFG_W-1:0] SYMBOL_COUNT_RST = 4'd12;

    // one coordinate pair after clamping, offset to 0 .. 2^32-1
    typedef struct packed {
        logic [AXIS_W-1:0] lat_u;
        logic [AXIS_W-1:0] lon_u;
    } axis_pair_t;

    localparam logic [SYMBOL_W-1:0] ALPHABET [32] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66, 7'h67,
        7'h68, 7'h6a, 7'h6b, 7'h6d, 7'h6e, 7'h70, 7'h71, 7'h72,
        7'h73, 7'h74, 7'h75, 7'h76, 7'h77, 7'h78, 7'h79, 7'h7a
    };

    function automatic logic [SYMBOL_W-1:0] symbol_of(input logic [BITS_PER_SYMBOL-1:0] code);
        return ALPHABET[code];
    endfunction

    // clamp to +-2^31 and offset; +2^31 bisects to all ones, same as 2^32-1
    function automatic logic [AXIS_W-1:0] axis_offset(input logic [COORD_W-1:0] v);
        logic below;
        logic above;
        below = v[COORD_W-1] && !(v[COORD_W-2] && v[COORD_W-3]);
        above = !v[COORD_W-1] && (v[COORD_W-2] || v[COORD_W-3]);
        if (below) begin
            return '0;
        end else if (above) begin
            return '1;
        end else begin
            return {~v[AXIS_W-1], v[AXIS_W-2:0]};
        end
    endfunction

endpackage
`default_nettype wire

// File: hdl/geohash_encoder.sv
// geohash encoder top level: configuration register, quantizer and serializer
//
// Takes one latitude/longitude request (34-bit two's complement, clamped to
// +-2^31) on the s_ channel and returns its geohash on the m_ channel as one
// ASCII character per m_ transfer, most significant first, with m_last on
// the final character. cfg_wr_en/cfg_wr_data set the character count
// (0..15, above MAX_SYMBOLS saturates, 0 drops the pair with no output);
// write it only while the block is idle.
// The first character passes the input register, clamp stage, serializer
// load and output register before it is valid.
// The serializer's shift register gives one character per cycle while m_ready
// is high; two pairs wait in the front stages while the serializer is busy.
// Reset (synchronous, aresetn low) empties every stage and sets the count to
// 12. When m_ready is low the output register holds and the stages behind it
// fill up, then s_ready falls; nothing is lost or repeated.
`default_nettype none
module geohash_encoder
    import gh_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_W-1:0]     cfg_wr_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [COORD_W-1:0]   s_lat_pos,
    input  wire logic [COORD_W-1:0]   s_lon_pos,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [SYMBOL_W-1:0]       m_symbol,
    output logic                      m_last
);

    localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);

    logic [CFG_W-1:0] symbol_count_reg;
    logic             q_valid;
    logic             q_ready;
    axis_pair_t       q_pair;
    logic [CNT_W-1:0] q_cnt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            symbol_count_reg <= SYMBOL_COUNT_RST;
        end else if (cfg_wr_en) begin
            symbol_count_reg <= cfg_wr_data;
        end
    end

    gh_quantize #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_quantize (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .lat_pos      (s_lat_pos),
        .lon_pos      (s_lon_pos),
        .symbol_count (symbol_count_reg),
        .out_valid    (q_valid),
        .out_ready    (q_ready),
        .out_pair     (q_pair),
        .out_cnt      (q_cnt)
    );

    gh_serializer #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_serializer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_pair  (q_pair),
        .in_cnt   (q_cnt),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_symbol (m_symbol),
        .m_last   (m_last)
    );

`ifndef SYNTH
    // output register must hold a stalled character
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_symbol) && $stable(m_last))
        else $error("stalled output character changed");

    // letters a, i, l and o are not in the base32 alphabet
    a_alphabet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_symbol != 7'h61 && m_symbol != 7'h69 &&
                     m_symbol != 7'h6c && m_symbol != 7'h6f))
        else $error("character outside geohash alphabet");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("pipeline not empty after reset");
`endif

endmodule
`default_nettype wire

// File: hdl/gh_quantize.sv
// input register, clamp/offset stage and symbol count capture
`default_nettype none
module gh_quantize
    import gh_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
    localparam int CNT_W = $clog2(MAX_SYMBOLS + 1)
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [COORD_W-1:0]  lat_pos,
    input  wire logic [COORD_W-1:0]  lon_pos,
    input  wire logic [CFG_W-1:0]    symbol_count,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output axis_pair_t               out_pair,
    output logic [CNT_W-1:0]         out_cnt
);

    logic               s1_valid_reg;
    logic [COORD_W-1:0] s1_lat_reg;
    logic [COORD_W-1:0] s1_lon_reg;
    logic [CNT_W-1:0]   s1_cnt_reg;
    logic [CNT_W-1:0]   s1_cnt_next;

    logic               s2_valid_reg;
    axis_pair_t         s2_pair_reg;
    logic [CNT_W-1:0]   s2_cnt_reg;

    logic s1_ready;
    logic s2_ready;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_comb begin
        if (symbol_count > CFG_W'(MAX_SYMBOLS)) begin
            s1_cnt_next = CNT_W'(MAX_SYMBOLS);
        end else begin
            s1_cnt_next = symbol_count[CNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            // a zero count request is taken and dropped here
            if (s1_ready) begin
                s1_valid_reg <= in_valid && (symbol_count != '0);
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && in_valid) begin
            s1_lat_reg <= lat_pos;
            s1_lon_reg <= lon_pos;
            s1_cnt_reg <= s1_cnt_next;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_pair_reg.lat_u <= axis_offset(s1_lat_reg);
            s2_pair_reg.lon_u <= axis_offset(s1_lon_reg);
            s2_cnt_reg        <= s1_cnt_reg;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_pair  = s2_pair_reg;
    assign out_cnt   = s2_cnt_reg;

endmodule
`default_nettype wire

// File: hdl/gh_serializer.sv
// bit interleave, character shift register and output register
`default_nettype none
module gh_serializer
    import gh_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
    localparam int CNT_W  = $clog2(MAX_SYMBOLS + 1),
    localparam int CODE_W = BITS_PER_SYMBOL * MAX_SYMBOLS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire axis_pair_t           in_pair,
    input  wire logic [CNT_W-1:0]     in_cnt,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [SYMBOL_W-1:0]       m_symbol,
    output logic                      m_last
);

    logic                ser_valid_reg;
    logic [CODE_W-1:0]   ser_code_reg;
    logic [CODE_W-1:0]   ser_code_next;
    logic [CNT_W-1:0]    ser_left_reg;
    logic                out_valid_reg;
    logic [SYMBOL_W-1:0] out_symbol_reg;
    logic                out_last_reg;

    logic [CODE_W-1:0]   code_load;
    logic                out_free;
    logic                emit;
    logic                emit_last;
    logic                load;

    // longitude takes the even bit positions, counted from the first bisection
    always_comb begin
        for (int i = 0; i < CODE_W; i++) begin
            if ((i % 2) == 0) begin
                code_load[CODE_W-1-i] = in_pair.lon_u[AXIS_W-1-(i/2)];
            end else begin
                code_load[CODE_W-1-i] = in_pair.lat_u[AXIS_W-1-(i/2)];
            end
        end
    end

    assign out_free  = !out_valid_reg || m_ready;
    assign emit      = ser_valid_reg && out_free;
    assign emit_last = emit && (ser_left_reg == CNT_W'(1));
    assign in_ready  = !ser_valid_reg || emit_last;
    assign load      = in_valid && in_ready;

    assign ser_code_next = ser_code_reg << BITS_PER_SYMBOL;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                ser_valid_reg <= 1'b1;
            end else if (emit_last) begin
                ser_valid_reg <= 1'b0;
            end
            if (out_free) begin
                out_valid_reg <= ser_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ser_code_reg <= code_load;
            ser_left_reg <= in_cnt;
        end else if (emit) begin
            ser_code_reg <= ser_code_next;
            ser_left_reg <= ser_left_reg - CNT_W'(1);
        end
        if (emit) begin
            out_symbol_reg <= symbol_of(ser_code_reg[CODE_W-1 -: BITS_PER_SYMBOL]);
            out_last_reg   <= (ser_left_reg == CNT_W'(1));
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_symbol = out_symbol_reg;
    assign m_last   = out_last_reg;

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// self-checking testbench for the geohash encoder: directed and random coordinate requests
`timescale 1ns / 100ps
module tb_top;
    import gh_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_ITEMS = 96;
    localparam longint HALF_SPAN = 64'sd2147483648;

    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                last;
    } geo_char_t;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]    cfg_wr_data = '0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    logic [COORD_W-1:0]  s_lat_pos   = '0;
    logic [COORD_W-1:0]  s_lon_pos   = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic [SYMBOL_W-1:0] m_symbol;
    logic                m_last;

    string            geo_alphabet = "0123456789bcdefghjkmnpqrstuvwxyz";
    geo_char_t        expected_chars[$];
    logic [CFG_W-1:0] symbol_count_cfg = SYMBOL_COUNT_RST;
    int               sender_idle_pct   = 0;
    int               receiver_stall_pct = 0;
    int               hold_left  = 0;
    int               mismatches = 0;

    geohash_encoder DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_lat_pos   (s_lat_pos),
        .s_lon_pos   (s_lon_pos),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_symbol    (m_symbol),
        .m_last      (m_last)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic longint clamp_axis(input logic [COORD_W-1:0] raw);
        longint v;
        v = $signed(raw);
        if (v < -HALF_SPAN) v = -HALF_SPAN;
        if (v > HALF_SPAN) v = HALF_SPAN;
        return v;
    endfunction

    // bisect longitude first, alternating axes, ties go to the upper half
    function automatic void predict_geohash(input logic [COORD_W-1:0] lat_raw,
                                            input logic [COORD_W-1:0] lon_raw);
        longint lat, lon, lat_lo, lat_hi, lon_lo, lon_hi, mid;
        int n;
        logic [BITS_PER_SYMBOL-1:0] code;
        bit on_lon;
        geo_char_t c;
        lat = clamp_axis(lat_raw);
        lon = clamp_axis(lon_raw);
        lat_lo = -HALF_SPAN;
        lat_hi = HALF_SPAN;
        lon_lo = -HALF_SPAN;
        lon_hi = HALF_SPAN;
        on_lon = 1'b1;
        n = (symbol_count_cfg > MAX_SYMBOLS_DEF) ? MAX_SYMBOLS_DEF : int'(symbol_count_cfg);
        for (int k = 0; k < n; k++) begin
            code = '0;
            for (int b = 0; b < BITS_PER_SYMBOL; b++) begin
                if (on_lon) begin
                    mid = (lon_lo + lon_hi) / 2;
                    if (lon >= mid) begin
                        code = {code[BITS_PER_SYMBOL-2:0], 1'b1};
                        lon_lo = mid;
                    end else begin
                        code = {code[BITS_PER_SYMBOL-2:0], 1'b0};
                        lon_hi = mid;
                    end
                end else begin
                    mid = (lat_lo + lat_hi) / 2;
                    if (lat >= mid) begin
                        code = {code[BITS_PER_SYMBOL-2:0], 1'b1};
                        lat_lo = mid;
                    end else begin
                        code = {code[BITS_PER_SYMBOL-2:0], 1'b0};
                        lat_hi = mid;
                    end
                end
                on_lon = !on_lon;
            end
            c.symbol = SYMBOL_W'(geo_alphabet[code]);
            c.last = (k == n - 1);
            expected_chars = {expected_chars, c};
        end
    endfunction

    // called right after a rising edge; returns at the edge that takes the request
    task automatic send_pair(input logic [COORD_W-1:0] lat, input logic [COORD_W-1:0] lon);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_lat_pos <= lat;
        s_lon_pos <= lon;
        do @(posedge aclk); while (!s_ready);
        predict_geohash(lat, lon);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge aclk);
        // zero-count requests leave nothing to wait for but may still be in flight
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_symbol_count(input logic [CFG_W-1:0] value);
        cfg_wr_en        <= 1'b1;
        cfg_wr_data      <= value;
        symbol_count_cfg  = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [COORD_W-1:0] random_coord();
        longint v;
        int     n;
        case ($urandom_range(9))
            6: v = $signed({2'($urandom_range(3)), 32'($urandom)});
            7: v = ($urandom_range(1) ? HALF_SPAN : -HALF_SPAN) + $urandom_range(4) - 2;
            8: begin
                // bisection grid points and their neighbors
                n = $urandom_range(31, 1);
                v = longint'($signed(32'($urandom))) & ~((64'sd1 <<< n) - 1);
                v = v + $urandom_range(2) - 1;
            end
            9: v = longint'($urandom_range(16)) - 8;
            default: v = longint'($signed(32'($urandom)));
        endcase
        return v[COORD_W-1:0];
    endfunction

    task automatic test_field_extremes();
        logic [COORD_W-1:0] corner[10];
        corner = '{34'h2_0000_0000, 34'h1_FFFF_FFFF, 34'h3_8000_0000, 34'h0_8000_0000,
                   34'h3_7FFF_FFFF, 34'h0_8000_0001, 34'h0_7FFF_FFFF, 34'h0_0000_0000,
                   34'h3_FFFF_FFFF, 34'h0_4000_0000};
        for (int i = 0; i < 10; i++) begin
            send_pair(corner[i], corner[9 - i]);
        end
        // exact midpoints on both axes
        send_pair(34'h0_4000_0000, 34'h0_0000_0000);
        send_pair(34'h3_C000_0000, 34'h3_C000_0000);
        wait_idle();
    endtask

    task automatic test_symbol_counts();
        logic [CFG_W-1:0] counts[7];
        counts = '{4'd0, 4'd1, 4'd5, 4'd11, 4'd13, 4'd15, 4'd12};
        foreach (counts[i]) begin
            set_symbol_count(counts[i]);
            send_pair(random_coord(), random_coord());
            send_pair(random_coord(), random_coord());
            wait_idle();
        end
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int chunk = 0; chunk < 3; chunk++) begin
            set_symbol_count($urandom_range(1) ? 4'(MAX_SYMBOLS_DEF)
                                               : 4'($urandom_range(15)));
            for (int i = 0; i < RANDOM_ITEMS / 3; i++) begin
                send_pair(random_coord(), random_coord());
            end
            wait_idle();
        end
    endtask

    task automatic test_output_hold_off();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        set_symbol_count(4'(MAX_SYMBOLS_DEF));
        hold_left = 300;
        for (int i = 0; i < 8; i++) begin
            send_pair(random_coord(), random_coord());
        end
        wait_idle();
    endtask

    // receiver side: random stalls plus the long hold-off
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge aclk) begin
        geo_char_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected character 0x%0h", m_symbol));
            end else begin
                want = expected_chars.pop_front();
                if (m_symbol !== want.symbol)
                    report_mismatch($sformatf("symbol 0x%0h, expected 0x%0h",
                                              m_symbol, want.symbol));
                if (m_last !== want.last)
                    report_mismatch($sformatf("last %b, expected %b", m_last, want.last));
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_field_extremes();
        test_symbol_counts();
        test_random_traffic(0, 0);
        test_random_traffic(66, 0);
        test_random_traffic(0, 66);
        test_random_traffic(38, 38);
        test_output_hold_off();
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/gh_pkg.sv
hdl/gh_quantize.sv
hdl/gh_serializer.sv
hdl/geohash_encoder.sv
tb/tb_top.sv
